>>> sv/mfb_pkg.sv
package mfb_pkg;

	// Default sizes of the converter
	localparam int DEF_MAX_WIDTH   = 512;
	localparam int DEF_MAX_HEIGHT  = 512;
	localparam int DEF_STORE_BYTES = 32768;

	// Field widths fixed by the interface
	localparam int CFG_W = 10;
	localparam int DIM_W = 11;
	localparam int IDX_W = 16;
	localparam int PAIRS = 4;

	// Queue depths
	localparam int CMDQ_DEPTH = 2;
	localparam int RQ_DEPTH   = 4;

	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	localparam logic [CFG_W-1:0] RST_PANEL_WIDTH   = 10'd400;
	localparam logic [CFG_W-1:0] RST_PANEL_HEIGHT  = 10'd300;
	localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 10'd400;
	localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 10'd300;

	typedef enum logic [1:0] {
		REG_PANEL_WIDTH   = 2'd0,
		REG_PANEL_HEIGHT  = 2'd1,
		REG_SOURCE_WIDTH  = 2'd2,
		REG_SOURCE_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FN_CLEAR = 2'd0,
		FN_PIXEL = 2'd1,
		FN_READ  = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic [CFG_W-1:0] panel_width;
		logic [CFG_W-1:0] panel_height;
		logic [CFG_W-1:0] source_width;
		logic [CFG_W-1:0] source_height;
	} cfg_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		func_t                         kind;
		logic                          fill;
		logic                          status;
		logic [PAIRS-1:0][IDX_W-1:0]   addr;
		logic [PAIRS-1:0][7:0]         mask;
	} cmd_t;

endpackage

>>> sv/mfb_front.sv
module mfb_front #(
	parameter int MAX_WIDTH   = mfb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = mfb_pkg::DEF_MAX_HEIGHT,
	parameter int STORE_BYTES = mfb_pkg::DEF_STORE_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mfb_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     func,
	input  logic [8:0]     row,
	input  logic [5:0]     column_byte,
	input  logic [7:0]     pixels,
	input  logic           fill_value,
	input  logic [14:0]    read_index,
	output logic           push,
	output mfb_pkg::cmd_t  cmd,
	input  logic           q_full
);
	import mfb_pkg::*;

	localparam logic [DIM_W-1:0] MaxW  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MaxH  = DIM_W'(MAX_HEIGHT);
	localparam logic [IDX_W:0]   Limit = (IDX_W+1)'(STORE_BYTES);

	logic        accept;
	logic        v_s1;
	func_t       func_s1;
	logic [8:0]  row_s1;
	logic [5:0]  colb_s1;
	logic [7:0]  pix_s1;
	logic        fill_s1;
	logic [14:0] ridx_s1;

	logic                        y_ok;
	logic [CFG_W-1:0]            flipped;
	logic [7:0]                  quarter;
	logic [7:0]                  fq;
	logic [13:0]                 base;
	logic [PAIRS-1:0][IDX_W-1:0] idx;
	logic [PAIRS-1:0]            idx_ok;
	logic [PAIRS-1:0][8:0]       xe;
	logic [PAIRS-1:0][8:0]       xo;
	logic [PAIRS-1:0]            ok_e;
	logic [PAIRS-1:0]            ok_o;
	logic [PAIRS-1:0][7:0]       mask;
	logic                        bad;

	function automatic logic x_in(input logic [8:0] x, input cfg_t c);
		return ({1'b0, x} < c.panel_width) && ({1'b0, x} < c.source_width) &&
			({2'b0, x} < MaxW);
	endfunction

	// Hold one request while the queue is full
	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_t'(func);
			row_s1  <= row;
			colb_s1 <= column_byte;
			pix_s1  <= pixels;
			fill_s1 <= fill_value;
			ridx_s1 <= read_index;
		end
	end

	// Flip the row and locate the four store bytes of the pixel pairs
	always_comb begin
		y_ok = ({1'b0, row_s1} < cfg.panel_height) && ({1'b0, row_s1} < cfg.source_height) &&
			({2'b0, row_s1} < MaxH);
		flipped = cfg.panel_height - CFG_W'(1) - {1'b0, row_s1};
		quarter = cfg.panel_height[CFG_W-1:2];
		fq      = flipped[CFG_W-1:2];
		base    = 14'(colb_s1) * 14'(quarter);
		bad     = 1'b0;
		for (int k = 0; k < PAIRS; k++) begin
			idx[k]    = IDX_W'({base, 2'b00}) + IDX_W'(k) * IDX_W'(quarter) + IDX_W'(fq);
			idx_ok[k] = {1'b0, idx[k]} < Limit;
			xe[k]     = {colb_s1, 2'(k), 1'b0};
			xo[k]     = {colb_s1, 2'(k), 1'b1};
			ok_e[k]   = x_in(xe[k], cfg) && y_ok && idx_ok[k];
			ok_o[k]   = x_in(xo[k], cfg) && y_ok && idx_ok[k];
			mask[k]   = {6'b0, pix_s1[7-2*k] && ok_e[k], pix_s1[6-2*k] && ok_o[k]}
				<< (3'd6 - {flipped[1:0], 1'b0});
			bad       = bad || !ok_e[k] || !ok_o[k];
		end
	end

	// Classify the request
	always_comb begin
		cmd      = '0;
		cmd.kind = func_s1;
		cmd.fill = fill_s1;
		case (func_s1)
			FN_CLEAR: begin
				cmd.status = 1'b0;
			end
			FN_PIXEL: begin
				cmd.addr   = idx;
				cmd.mask   = mask;
				cmd.status = bad;
			end
			FN_READ: begin
				cmd.addr[0] = IDX_W'(ridx_s1);
				cmd.status  = !({2'b0, ridx_s1} < Limit);
			end
			default: begin
				cmd.status = 1'b1;
			end
		endcase
	end

endmodule

>>> sv/mfb_queue.sv
module mfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mfb_pkg::cmd_t  cmd_in,
	output logic           full,
	input  logic           pop,
	output mfb_pkg::cmd_t  cmd_out,
	output logic           empty
);
	import mfb_pkg::*;

	localparam int PW = $clog2(CMDQ_DEPTH);
	localparam int CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          entry_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = cnt_q == CW'(CMDQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign cmd_out = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

>>> sv/mfb_back.sv
module mfb_back #(
	parameter int STORE_BYTES = mfb_pkg::DEF_STORE_BYTES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mfb_pkg::cmd_t  q_cmd,
	input  logic           q_empty,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     read_data,
	output logic           status
);
	import mfb_pkg::*;

	localparam int AW  = $clog2(STORE_BYTES);
	localparam int PW  = $clog2(PAIRS);
	localparam int RPW = $clog2(RQ_DEPTH);
	localparam int RCW = $clog2(RQ_DEPTH + 1);
	localparam logic [AW-1:0] LastClr  = AW'(STORE_BYTES - 1);
	localparam logic [PW-1:0] LastPair = PW'(PAIRS - 1);

	logic [7:0] mem [STORE_BYTES];

	logic           busy_q;
	cmd_t           cur_q;
	logic [AW-1:0]  op_cnt_q;
	logic [RCW-1:0] res_cnt_q;
	logic           load;

	logic [AW-1:0]  iss_addr;
	logic [7:0]     iss_mask;
	logic           iss_wr;
	logic           iss_last;

	logic           wr_s1;
	logic           done_s1;
	logic [AW-1:0]  addr_s1;
	logic [7:0]     mask_s1;
	logic           clr_s1;
	logic           fill_s1;
	logic           status_s1;
	logic           rd_s1;
	logic [7:0]     rdata_s1;

	logic           lw_v_q;
	logic [AW-1:0]  lw_addr_q;
	logic [7:0]     lw_data_q;
	logic [7:0]     merged;
	logic [7:0]     wdata;
	logic [7:0]     res_data;

	logic [7:0]     rq_data_q [RQ_DEPTH];
	logic           rq_status_q [RQ_DEPTH];
	logic [RPW-1:0] rq_wr_q;
	logic [RPW-1:0] rq_rd_q;
	logic [RCW-1:0] rq_cnt_q;
	logic           out_pop;

	// Expand the current request into store operations
	always_comb begin
		iss_addr = '0;
		iss_mask = BYTE_ZERO;
		iss_wr   = 1'b0;
		iss_last = 1'b1;
		case (cur_q.kind)
			FN_CLEAR: begin
				iss_addr = op_cnt_q;
				iss_wr   = 1'b1;
				iss_last = op_cnt_q == LastClr;
			end
			FN_PIXEL: begin
				iss_addr = cur_q.addr[op_cnt_q[PW-1:0]][AW-1:0];
				iss_mask = cur_q.mask[op_cnt_q[PW-1:0]];
				iss_wr   = |iss_mask;
				iss_last = op_cnt_q[PW-1:0] == LastPair;
			end
			FN_READ: begin
				iss_addr = cur_q.addr[0][AW-1:0];
			end
			default: begin
				iss_last = 1'b1;
			end
		endcase
	end

	// Take the next request when a result slot is free for it and the back end is idle or on its last access
	assign load  = !q_empty && (res_cnt_q < RCW'(RQ_DEPTH)) && (!busy_q || iss_last);
	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			op_cnt_q  <= '0;
			res_cnt_q <= '0;
			wr_s1     <= 1'b0;
			done_s1   <= 1'b0;
			lw_v_q    <= 1'b0;
		end else begin
			busy_q <= load || (busy_q && !iss_last);
			if (busy_q && iss_last) begin
				op_cnt_q <= '0;
			end else if (busy_q) begin
				op_cnt_q <= op_cnt_q + AW'(1);
			end
			if (load && !out_pop) begin
				res_cnt_q <= res_cnt_q + RCW'(1);
			end else if (out_pop && !load) begin
				res_cnt_q <= res_cnt_q - RCW'(1);
			end
			wr_s1   <= busy_q && iss_wr;
			done_s1 <= busy_q && iss_last;
			lw_v_q  <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_cmd;
		end
		addr_s1   <= iss_addr;
		mask_s1   <= iss_mask;
		clr_s1    <= cur_q.kind == FN_CLEAR;
		rd_s1     <= cur_q.kind == FN_READ;
		fill_s1   <= cur_q.fill;
		status_s1 <= cur_q.status;
		if (wr_s1) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= wdata;
		end
	end

	// Store: one read and one write port, read data registered
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[addr_s1] <= wdata;
		end
		if (busy_q) begin
			rdata_s1 <= mem[iss_addr];
		end
	end

	// Forward the write that landed on the same edge as the read
	assign merged   = (lw_v_q && lw_addr_q == addr_s1) ? lw_data_q : rdata_s1;
	assign wdata    = clr_s1 ? (fill_s1 ? BYTE_ONES : BYTE_ZERO) : (merged | mask_s1);
	assign res_data = (rd_s1 && !status_s1) ? merged : BYTE_ZERO;

	// Result queue toward the output
	assign out_valid = rq_cnt_q != '0;
	assign out_pop   = out_valid && !out_stall;
	assign read_data = rq_data_q[rq_rd_q];
	assign status    = rq_status_q[rq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (done_s1) begin
				rq_wr_q <= rq_wr_q + RPW'(1);
			end
			if (out_pop) begin
				rq_rd_q <= rq_rd_q + RPW'(1);
			end
			if (done_s1 && !out_pop) begin
				rq_cnt_q <= rq_cnt_q + RCW'(1);
			end else if (out_pop && !done_s1) begin
				rq_cnt_q <= rq_cnt_q - RCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			rq_data_q[rq_wr_q]   <= res_data;
			rq_status_q[rq_wr_q] <= status_s1;
		end
	end

endmodule

>>> sv/mono_framebuffer_block_remap.sv
// Converts a row-major, MSB-first 1-bit image into the panel's block layout
// held in an internal byte store, one source byte (eight pixels) per request;
// rows are flipped vertically and every request returns one result (read
// byte or zero, plus an out-of-area status). A pixel request does one
// read-modify-write per store byte of its four pixel pairs through the store's
// single read and single write port; read and unused requests do one store
// access; a clear request sweeps the whole store at one byte per cycle. The
// result is registered in s1 and then in the result queue before it is offered.
// The front end classifies requests and queues up to two ahead of the back
// end, and up to four results wait at the output. The store comes out of reset
// undefined: read only bytes that were cleared or written since. The user must
// write registers only while the block is idle; the block does not enforce it.
module mono_framebuffer_block_remap #(
	parameter int MAX_WIDTH   = mfb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT  = mfb_pkg::DEF_MAX_HEIGHT,
	parameter int STORE_BYTES = mfb_pkg::DEF_STORE_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [8:0]  row,
	input  logic [5:0]  column_byte,
	input  logic [7:0]  pixels,
	input  logic        fill_value,
	input  logic [14:0] read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        status
);
	import mfb_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_t reg_sel;
	logic     cfg_wr;

	cmd_t f_cmd;
	cmd_t q_cmd;
	logic f_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.panel_width   <= RST_PANEL_WIDTH;
			cfg_q.panel_height  <= RST_PANEL_HEIGHT;
			cfg_q.source_width  <= RST_SOURCE_WIDTH;
			cfg_q.source_height <= RST_SOURCE_HEIGHT;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_PANEL_WIDTH:   cfg_q.panel_width   <= pwdata[CFG_W-1:0];
				REG_PANEL_HEIGHT:  cfg_q.panel_height  <= pwdata[CFG_W-1:0];
				REG_SOURCE_WIDTH:  cfg_q.source_width  <= pwdata[CFG_W-1:0];
				REG_SOURCE_HEIGHT: cfg_q.source_height <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_sel)
			REG_PANEL_WIDTH:   prdata = 32'(cfg_q.panel_width);
			REG_PANEL_HEIGHT:  prdata = 32'(cfg_q.panel_height);
			REG_SOURCE_WIDTH:  prdata = 32'(cfg_q.source_width);
			REG_SOURCE_HEIGHT: prdata = 32'(cfg_q.source_height);
			default:           prdata = '0;
		endcase
	end

	mfb_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.row         (row),
		.column_byte (column_byte),
		.pixels      (pixels),
		.fill_value  (fill_value),
		.read_index  (read_index),
		.push        (f_push),
		.cmd         (f_cmd),
		.q_full      (q_full)
	);

	mfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.cmd_in  (f_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.cmd_out (q_cmd),
		.empty   (q_empty)
	);

	mfb_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (q_cmd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.status    (status)
	);

endmodule

>>> test/mono_framebuffer_block_remap_tb.sv
`timescale 1ns / 1ps

module mono_framebuffer_block_remap_tb;

	import mfb_pkg::*;

	localparam int MAX_W        = DEF_MAX_WIDTH;
	localparam int MAX_H        = DEF_MAX_HEIGHT;
	localparam int STORE_BYTES  = DEF_STORE_BYTES;
	localparam int IDLE_LIMIT   = 150000;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 200;
	localparam int DIR_ROWS     = 20;

	typedef struct packed {
		func_t       func;
		logic [8:0]  row;
		logic [5:0]  column_byte;
		logic [7:0]  pixels;
		logic        fill;
		logic [14:0] read_index;
	} request_t;

	typedef struct packed {
		logic [7:0] data;
		logic       status;
	} result_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		result_t  want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = '0;
	logic [8:0]  row = '0;
	logic [5:0]  column_byte = '0;
	logic [7:0]  pixels = '0;
	logic        fill_value = 1'b0;
	logic [14:0] read_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  read_data;
	logic        status;

	// Predictor state: panel settings and a shadow of the byte store
	int          cfg_pw = RST_PANEL_WIDTH;
	int          cfg_ph = RST_PANEL_HEIGHT;
	int          cfg_sw = RST_SOURCE_WIDTH;
	int          cfg_sh = RST_SOURCE_HEIGHT;
	logic [7:0]  shadow_store [STORE_BYTES];

	result_t     pending_results [$];
	result_t     oldest;
	int          fail_count = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          cycle_count = 0;
	logic        send_calm = 1'b0;
	logic        recv_calm = 1'b0;

	// Directed rows, default 400x300 panel and source
	dir_row_t directed [DIR_ROWS] = '{
		'{'{FN_CLEAR, 9'd0,   6'd0,  8'h00, 1'b1, 15'd0},     1'b1, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd0},     1'b1, '{8'hFF, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'h7FFF},  1'b1, '{8'hFF, 1'b0}},
		'{'{FN_CLEAR, 9'd0,   6'd0,  8'h00, 1'b0, 15'd0},     1'b1, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd0},     1'b1, '{8'h00, 1'b0}},
		'{'{FN_PIXEL, 9'd0,   6'd0,  8'hFF, 1'b1, 15'h7FFF},  1'b0, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd74},    1'b0, '{8'h00, 1'b0}},
		'{'{FN_PIXEL, 9'd299, 6'd49, 8'h81, 1'b0, 15'd0},     1'b0, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd14700}, 1'b0, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd14925}, 1'b0, '{8'h00, 1'b0}},
		'{'{FN_PIXEL, 9'd300, 6'd0,  8'hFF, 1'b0, 15'd0},     1'b1, '{8'h00, 1'b1}},
		'{'{FN_PIXEL, 9'd511, 6'd63, 8'h00, 1'b1, 15'd0},     1'b1, '{8'h00, 1'b1}},
		'{'{FN_PIXEL, 9'd0,   6'd50, 8'hFF, 1'b0, 15'd0},     1'b1, '{8'h00, 1'b1}},
		'{'{FN_PIXEL, 9'd150, 6'd10, 8'hAA, 1'b0, 15'd0},     1'b0, '{8'h00, 1'b0}},
		'{'{FN_PIXEL, 9'd151, 6'd10, 8'h55, 1'b0, 15'd0},     1'b0, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd3037},  1'b0, '{8'h00, 1'b0}},
		'{'{FN_NONE,  9'd511, 6'd63, 8'hFF, 1'b1, 15'h7FFF},  1'b1, '{8'h00, 1'b1}},
		'{'{FN_NONE,  9'd0,   6'd0,  8'h00, 1'b0, 15'd0},     1'b1, '{8'h00, 1'b1}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd74},    1'b0, '{8'h00, 1'b0}},
		'{'{FN_READ,  9'd0,   6'd0,  8'h00, 1'b0, 15'd14850}, 1'b0, '{8'h00, 1'b0}}
	};

	cfg_t fixed_settings [4] = '{
		'{10'd2,   10'd4,   10'd1,   10'd1},
		'{10'd512, 10'd512, 10'd512, 10'd512},
		'{10'd400, 10'd301, 10'd256, 10'd200},
		'{10'd16,  10'd8,   10'd512, 10'd3}
	};

	mono_framebuffer_block_remap DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.row         (row),
		.column_byte (column_byte),
		.pixels      (pixels),
		.fill_value  (fill_value),
		.read_index  (read_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.status      (status)
	);

	always #1 clk = ~clk;

	function automatic int least(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Work out the result of one request and update the shadow store
	task automatic convert_request(input request_t rq, output result_t res);
		int x;
		int flip;
		int idx;
		res = '0;
		case (rq.func)
		FN_CLEAR: begin
			foreach (shadow_store[k])
				shadow_store[k] = rq.fill ? BYTE_ONES : BYTE_ZERO;
		end
		FN_PIXEL: begin
			for (int i = 0; i < 8; i++) begin
				x = int'(rq.column_byte) * 8 + i;
				if (x >= cfg_pw || x >= cfg_sw || x >= MAX_W || rq.row >= cfg_ph ||
						rq.row >= cfg_sh || rq.row >= MAX_H) begin
					res.status = 1'b1;
				end else begin
					flip = cfg_ph - 1 - int'(rq.row);
					idx = (x >> 1) * (cfg_ph >> 2) + (flip >> 2);
					if (idx >= STORE_BYTES)
						res.status = 1'b1;
					else if (rq.pixels[7-i])
						shadow_store[idx][7 - ((flip & 3) * 2 + (x & 1))] = 1'b1;
				end
			end
		end
		FN_READ: begin
			if (int'(rq.read_index) < STORE_BYTES)
				res.data = shadow_store[rq.read_index];
			else
				res.status = 1'b1;
		end
		default: res.status = 1'b1;
		endcase
	endtask

	// Hold a request until it is taken, then record what it should return
	task automatic send_request(input request_t rq, input logic typed, input result_t want);
		int gap;
		result_t predicted;
		gap = send_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= rq.func;
		row <= rq.row;
		column_byte <= rq.column_byte;
		pixels <= rq.pixels;
		fill_value <= rq.fill;
		read_index <= rq.read_index;
		do @(posedge clk); while (in_stall);
		convert_request(rq, predicted);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= {22'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (which)
		REG_PANEL_WIDTH:   cfg_pw = value;
		REG_PANEL_HEIGHT:  cfg_ph = value;
		REG_SOURCE_WIDTH:  cfg_sw = value;
		REG_SOURCE_HEIGHT: cfg_sh = value;
		default: ;
		endcase
	endtask

	// Mostly in-area pixel bytes and reads within the area, some noise
	function automatic request_t random_request();
		request_t rq;
		int r;
		int xlim;
		int ylim;
		int top;
		rq.func = FN_PIXEL;
		rq.row = 9'($urandom_range(0, 511));
		rq.column_byte = 6'($urandom_range(0, 63));
		rq.pixels = 8'($urandom & $urandom);
		rq.fill = ($urandom_range(0, 3) == 0);
		rq.read_index = 15'($urandom_range(0, 32767));
		xlim = least(least(cfg_pw, cfg_sw), MAX_W);
		ylim = least(least(cfg_ph, cfg_sh), MAX_H);
		top = least(((xlim - 1) >> 1) * (cfg_ph >> 2) + ((cfg_ph - 1) >> 2), STORE_BYTES - 1);
		r = $urandom_range(0, 999);
		if (r < 8) begin
			rq.func = FN_CLEAR;
		end else if (r < 40) begin
			rq.func = FN_NONE;
		end else if (r < 340) begin
			rq.func = FN_READ;
			if ($urandom_range(0, 3) != 0)
				rq.read_index = 15'($urandom_range(0, top));
		end else if (r < 440) begin
			rq.pixels = 8'($urandom_range(0, 255));
		end else begin
			rq.row = 9'($urandom_range(0, ylim - 1));
			rq.column_byte = 6'($urandom_range(0, (xlim - 1) / 8));
		end
		return rq;
	endfunction

	// Receive results, check them in order, stall at random
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 0)
			recv_calm <= ($urandom_range(0, 3) == 0);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: read_data %02h status %0d", read_data, status);
				fail_count++;
			end else begin
				oldest = pending_results.pop_front();
				if (read_data !== oldest.data) begin
					$error("read_data: expected %02h, got %02h", oldest.data, read_data);
					fail_count++;
				end
				if (status !== oldest.status) begin
					$error("status: expected %0d, got %0d", oldest.status, status);
					fail_count++;
				end
			end
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!recv_calm && $urandom_range(0, 99) < 30)
				stall_left <= pick_gap();
		end
	end

	// Watchdog: give up after a long stretch with nothing accepted or delivered
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		cfg_t setting;
		request_t rq;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed rows; the first clear defines the whole store
		foreach (directed[i])
			send_request(directed[i].rq, directed[i].typed, directed[i].want);

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			if (p < 4) begin
				setting = fixed_settings[p];
			end else begin
				setting.panel_width = 10'(2 * $urandom_range(1, 256));
				setting.panel_height = 10'(4 * $urandom_range(1, 128));
				setting.source_width = 10'($urandom_range(1, 512));
				setting.source_height = 10'($urandom_range(1, 512));
			end
			write_register(REG_PANEL_WIDTH, setting.panel_width);
			write_register(REG_PANEL_HEIGHT, setting.panel_height);
			write_register(REG_SOURCE_WIDTH, setting.source_width);
			write_register(REG_SOURCE_HEIGHT, setting.source_height);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 50 == 0)
					send_calm = ($urandom_range(0, 3) == 0);
				// hold off once per phase until the block runs dry
				if (n == PHASE_ITEMS / 2)
					drain_results();
				rq = random_request();
				send_request(rq, 1'b0, '0);
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
